// ===== hdl/sqg_pkg.sv =====
// ----------------------------------------------------------------------------
// sqg_pkg: shared types and constants for the single-qubit gate block
// Store geometry, fixed-point format, operation and status codes, register
// indexes and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package sqg_pkg;

  // Store geometry
  localparam int MAX_QUBITS = 10;
  localparam int ADDR_W     = MAX_QUBITS;
  localparam int PAIR_W     = ADDR_W - 1;
  localparam int DEPTH      = 1 << ADDR_W;
  localparam int QCNT_W     = 4;

  // Amplitude format: Q2.30 by default
  localparam int AMP_WIDTH  = 32;
  localparam int FRAC_BITS  = AMP_WIDTH - 2;
  localparam int STORE_W    = 2 * AMP_WIDTH;
  localparam int PORT_W     = 32;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_W      = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_M00  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_M01  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_M10  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_M11  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_QCNT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_WIRE = 3'd5;

  // Matrix element reset values: 1.0 + 0i and 0
  localparam logic [CFG_W-1:0] GATE_ONE  = CFG_W'(1) << (32 + FRAC_BITS);
  localparam logic [CFG_W-1:0] GATE_ZERO = '0;
  localparam logic [QCNT_W-1:0] QCNT_RESET = QCNT_W'(MAX_QUBITS);

  // Item operation codes
  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_APPLY = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_INDEX = 2'd1;
  localparam logic [1:0] ST_BAD_WIRE  = 2'd2;

  // Store write source
  typedef enum logic [1:0] {
    WR_ZERO,
    WR_HOST,
    WR_PAIR_LO,
    WR_PAIR_HI
  } wr_src_e;

  typedef struct packed {
    logic [CFG_W-1:0] m00;
    logic [CFG_W-1:0] m01;
    logic [CFG_W-1:0] m10;
    logic [CFG_W-1:0] m11;
  } sqg_gate_t;

  // Controller to datapath
  typedef struct packed {
    logic       mem_we;
    wr_src_e    wr_src;
    logic       rd_en;
    logic       rd_apply;
    logic       mul_hi;
    logic       cnt_clr;
    logic       cnt_inc;
    logic       res_load;
    logic       res_mem;
    logic [1:0] res_status;
  } sqg_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic idx_oob;
    logic wire_oob;
    logic pair_last;
    logic cnt_last;
  } sqg_flag_t;

endpackage

`default_nettype wire

// ===== hdl/single_qubit_gate_apply.sv =====
// ----------------------------------------------------------------------------
// single_qubit_gate_apply: 2x2 complex gate on a fixed-point state vector
// Holds 2^n Q2.30 complex amplitudes; items write or read one amplitude or
// apply the configured matrix to every amplitude pair of the target qubit.
//
//   channel   signals                                   handshake
//   item in   mode_i amp_index_i in_re_i in_im_i        start_i & !busy_o
//   result    out_re_o out_im_o status_o                done_o (one cycle)
//   config    cfg_idx_i cfg_wdata_i                     cfg_we_i
//
// A write, a rejected item or an unused mode gives its result in the cycle
// after accept; a read passes through the registered store read port first.
// An apply works through every amplitude pair in turn, each with one read
// of both pair entries, two multiply passes through the eight-multiplier
// MAC, and two write-backs through the single store write port.
// After reset a clear sweep zeroes the whole store with busy high;
// configuration writes are taken during it. Results cannot be held off.
// ----------------------------------------------------------------------------
`default_nettype none

module single_qubit_gate_apply import sqg_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  output      logic                 busy_o,
  input  wire logic [1:0]           mode_i,
  input  wire logic [ADDR_W-1:0]    amp_index_i,
  input  wire logic [PORT_W-1:0]    in_re_i,
  input  wire logic [PORT_W-1:0]    in_im_i,
  output      logic                 done_o,
  output      logic [PORT_W-1:0]    out_re_o,
  output      logic [PORT_W-1:0]    out_im_o,
  output      logic [1:0]           status_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_wdata_i
);

  sqg_gate_t         gate_q;
  logic [QCNT_W-1:0] qcnt_q, wire_q, n_eff;
  sqg_cmd_t          cmd;
  sqg_flag_t         flags;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gate_q.m00 <= GATE_ONE;
      gate_q.m01 <= GATE_ZERO;
      gate_q.m10 <= GATE_ZERO;
      gate_q.m11 <= GATE_ONE;
      qcnt_q     <= QCNT_RESET;
      wire_q     <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_M00:  gate_q.m00 <= cfg_wdata_i;
        CFG_M01:  gate_q.m01 <= cfg_wdata_i;
        CFG_M10:  gate_q.m10 <= cfg_wdata_i;
        CFG_M11:  gate_q.m11 <= cfg_wdata_i;
        CFG_QCNT: qcnt_q     <= cfg_wdata_i[QCNT_W-1:0];
        CFG_WIRE: wire_q     <= cfg_wdata_i[QCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the qubit count to the store size
  assign n_eff = (qcnt_q > QCNT_W'(MAX_QUBITS)) ? QCNT_W'(MAX_QUBITS) : qcnt_q;

  sqg_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .mode_i  (mode_i),
    .flags_i (flags),
    .cmd_o   (cmd),
    .busy_o  (busy_o),
    .done_o  (done_o)
  );

  sqg_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .flags_o     (flags),
    .gate_i      (gate_q),
    .n_i         (n_eff),
    .wire_i      (wire_q),
    .amp_index_i (amp_index_i),
    .in_re_i     (in_re_i),
    .in_im_i     (in_im_i),
    .out_re_o    (out_re_o),
    .out_im_o    (out_im_o),
    .status_o    (status_o)
  );

endmodule

`default_nettype wire

// ===== hdl/sqg_dp.sv =====
// ----------------------------------------------------------------------------
// sqg_dp: amplitude store and complex multiply-accumulate datapath
// Holds the state store, pair address generation, the pass counter, a
// three-stage complex MAC with round and saturate, and the result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module sqg_dp import sqg_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire sqg_cmd_t              cmd_i,
  output      sqg_flag_t             flags_o,
  input  wire sqg_gate_t             gate_i,
  input  wire logic [QCNT_W-1:0]     n_i,
  input  wire logic [QCNT_W-1:0]     wire_i,
  input  wire logic [ADDR_W-1:0]     amp_index_i,
  input  wire logic [PORT_W-1:0]     in_re_i,
  input  wire logic [PORT_W-1:0]     in_im_i,
  output      logic [PORT_W-1:0]     out_re_o,
  output      logic [PORT_W-1:0]     out_im_o,
  output      logic [1:0]            status_o
);

  localparam int PROD_W = 2 * AMP_WIDTH;
  localparam int PSUM_W = PROD_W + 1;
  localparam int SUM_W  = PROD_W + 3;

  localparam logic signed [SUM_W-1:0] RND_HALF = SUM_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [SUM_W-1:0] AMP_MAX  =
    SUM_W'({1'b0, {(AMP_WIDTH-1){1'b1}}});
  localparam logic signed [SUM_W-1:0] AMP_MIN  = ~AMP_MAX;

  // Round half up and saturate the exact sum of two partial sums
  function automatic logic [AMP_WIDTH-1:0] round_sat(
    input logic signed [PSUM_W-1:0] a,
    input logic signed [PSUM_W-1:0] b
  );
    logic signed [SUM_W-1:0] s;
    logic signed [SUM_W-1:0] q;
    s = SUM_W'(a) + SUM_W'(b) + RND_HALF;
    q = s >>> FRAC_BITS;
    if (q > AMP_MAX) begin
      return AMP_MAX[AMP_WIDTH-1:0];
    end else if (q < AMP_MIN) begin
      return AMP_MIN[AMP_WIDTH-1:0];
    end
    return q[AMP_WIDTH-1:0];
  endfunction

  logic [STORE_W-1:0] mem_q [DEPTH];
  logic [STORE_W-1:0] rda_q, rdb_q;
  logic [ADDR_W-1:0]  cnt_q;
  logic [ADDR_W-1:0]  i0, i1, rd_addr_a, waddr;
  logic [ADDR_W-1:0]  kx;
  logic [QCNT_W-1:0]  bpos;
  logic [STORE_W-1:0] wdata;

  logic signed [PROD_W-1:0] pr_q [4];
  logic signed [PROD_W-1:0] pi_q [4];
  logic signed [PSUM_W-1:0] re_a_q, re_b_q, im_a_q, im_b_q;
  logic [STORE_W-1:0]       wq_q;

  logic [PORT_W-1:0] res_re_q, res_im_q;
  logic [1:0]        res_status_q;

  logic [CFG_W-1:0]         ma, mb;
  logic signed [AMP_WIDTH-1:0] ar, ai, br, bi, xr, xi, yr, yi;

  // Range checks
  always_comb begin
    flags_o.idx_oob = 1'b0;
    for (int j = 0; j < ADDR_W; j++) begin
      if (QCNT_W'(j) >= n_i && amp_index_i[j]) begin
        flags_o.idx_oob = 1'b1;
      end
    end
    flags_o.wire_oob = (wire_i >= n_i);
    flags_o.pair_last = 1'b1;
    for (int j = 0; j < PAIR_W; j++) begin
      if (QCNT_W'(j + 1) < n_i && !cnt_q[j]) begin
        flags_o.pair_last = 1'b0;
      end
    end
    flags_o.cnt_last = &cnt_q;
  end

  // Pair addresses: insert a zero at the target bit, then set it
  always_comb begin
    bpos = n_i - wire_i - QCNT_W'(1);
    kx   = {1'b0, cnt_q[PAIR_W-1:0]};
    i0[0] = (bpos == '0) ? 1'b0 : kx[0];
    for (int j = 1; j < ADDR_W; j++) begin
      if (QCNT_W'(j) < bpos) begin
        i0[j] = kx[j];
      end else if (QCNT_W'(j) == bpos) begin
        i0[j] = 1'b0;
      end else begin
        i0[j] = kx[j-1];
      end
    end
    i1 = i0 | (ADDR_W'(1) << bpos);
    rd_addr_a = cmd_i.rd_apply ? i0 : amp_index_i;
  end

  // Pass counter: clear sweep address or pair number
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.cnt_clr) begin
      cnt_q <= '0;
    end else if (cmd_i.cnt_inc) begin
      cnt_q <= cnt_q + ADDR_W'(1);
    end
  end

  // Select the store write source
  always_comb begin
    case (cmd_i.wr_src)
      WR_ZERO: begin
        waddr = cnt_q;
        wdata = '0;
      end
      WR_HOST: begin
        waddr = amp_index_i;
        wdata = {in_re_i[AMP_WIDTH-1:0], in_im_i[AMP_WIDTH-1:0]};
      end
      WR_PAIR_LO: begin
        waddr = i0;
        wdata = wq_q;
      end
      default: begin
        waddr = i1;
        wdata = wq_q;
      end
    endcase
  end

  // Store: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_we) begin
      mem_q[waddr] <= wdata;
    end
    if (cmd_i.rd_en) begin
      rda_q <= mem_q[rd_addr_a];
      rdb_q <= mem_q[i1];
    end
  end

  // Pick the matrix row and split operands
  always_comb begin
    ma = cmd_i.mul_hi ? gate_i.m10 : gate_i.m00;
    mb = cmd_i.mul_hi ? gate_i.m11 : gate_i.m01;
    ar = ma[32 +: AMP_WIDTH];
    ai = ma[0 +: AMP_WIDTH];
    br = mb[32 +: AMP_WIDTH];
    bi = mb[0 +: AMP_WIDTH];
    xr = rda_q[AMP_WIDTH +: AMP_WIDTH];
    xi = rda_q[0 +: AMP_WIDTH];
    yr = rdb_q[AMP_WIDTH +: AMP_WIDTH];
    yi = rdb_q[0 +: AMP_WIDTH];
  end

  // MAC pipeline: products, partial sums, round and saturate
  always_ff @(posedge clk_i) begin
    pr_q[0] <= ar * xr;
    pr_q[1] <= ai * xi;
    pr_q[2] <= br * yr;
    pr_q[3] <= bi * yi;
    pi_q[0] <= ar * xi;
    pi_q[1] <= ai * xr;
    pi_q[2] <= br * yi;
    pi_q[3] <= bi * yr;

    re_a_q <= PSUM_W'(pr_q[0]) - PSUM_W'(pr_q[1]);
    re_b_q <= PSUM_W'(pr_q[2]) - PSUM_W'(pr_q[3]);
    im_a_q <= PSUM_W'(pi_q[0]) + PSUM_W'(pi_q[1]);
    im_b_q <= PSUM_W'(pi_q[2]) + PSUM_W'(pi_q[3]);

    wq_q <= {round_sat(re_a_q, re_b_q), round_sat(im_a_q, im_b_q)};
  end

  // Result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      res_status_q <= cmd_i.res_status;
      if (cmd_i.res_mem) begin
        res_re_q <= PORT_W'(signed'(rda_q[AMP_WIDTH +: AMP_WIDTH]));
        res_im_q <= PORT_W'(signed'(rda_q[0 +: AMP_WIDTH]));
      end else begin
        res_re_q <= '0;
        res_im_q <= '0;
      end
    end
  end

  assign out_re_o = res_re_q;
  assign out_im_o = res_im_q;
  assign status_o = res_status_q;

endmodule

`default_nettype wire

// ===== hdl/sqg_ctrl.sv =====
// ----------------------------------------------------------------------------
// sqg_ctrl: sequencer for the single-qubit gate block
// Runs the clear sweep after reset, decodes items, and steps the datapath
// through read, two multiply passes and two write-backs for each pair.
// ----------------------------------------------------------------------------
`default_nettype none

module sqg_ctrl import sqg_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start_i,
  input  wire logic [1:0] mode_i,
  input  wire sqg_flag_t  flags_i,
  output      sqg_cmd_t   cmd_o,
  output      logic       busy_o,
  output      logic       done_o
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_RD_RESP,
    S_AP_RD,
    S_AP_M0,
    S_AP_M1,
    S_AP_AD,
    S_AP_W0,
    S_AP_W1
  } state_e;

  state_e state_q, state_d;
  logic   busy_q, done_q, done_d;

  // Decode state and item into datapath commands
  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    cmd_o   = '0;
    cmd_o.wr_src     = WR_ZERO;
    cmd_o.res_status = ST_OK;

    unique case (state_q)
      S_CLEAR: begin
        cmd_o.mem_we = 1'b1;
        cmd_o.wr_src = WR_ZERO;
        if (flags_i.cnt_last) begin
          cmd_o.cnt_clr = 1'b1;
          state_d = S_IDLE;
        end else begin
          cmd_o.cnt_inc = 1'b1;
        end
      end
      S_IDLE: begin
        if (start_i) begin
          unique case (mode_i)
            MODE_WRITE: begin
              cmd_o.res_load = 1'b1;
              done_d = 1'b1;
              if (flags_i.idx_oob) begin
                cmd_o.res_status = ST_BAD_INDEX;
              end else begin
                cmd_o.mem_we = 1'b1;
                cmd_o.wr_src = WR_HOST;
              end
            end
            MODE_READ: begin
              if (flags_i.idx_oob) begin
                cmd_o.res_load   = 1'b1;
                cmd_o.res_status = ST_BAD_INDEX;
                done_d = 1'b1;
              end else begin
                cmd_o.rd_en = 1'b1;
                state_d = S_RD_RESP;
              end
            end
            MODE_APPLY: begin
              if (flags_i.wire_oob) begin
                cmd_o.res_load   = 1'b1;
                cmd_o.res_status = ST_BAD_WIRE;
                done_d = 1'b1;
              end else begin
                cmd_o.cnt_clr = 1'b1;
                state_d = S_AP_RD;
              end
            end
            default: begin
              cmd_o.res_load = 1'b1;
              done_d = 1'b1;
            end
          endcase
        end
      end
      S_RD_RESP: begin
        cmd_o.res_load = 1'b1;
        cmd_o.res_mem  = 1'b1;
        done_d  = 1'b1;
        state_d = S_IDLE;
      end
      S_AP_RD: begin
        cmd_o.rd_en    = 1'b1;
        cmd_o.rd_apply = 1'b1;
        state_d = S_AP_M0;
      end
      S_AP_M0: begin
        state_d = S_AP_M1;
      end
      S_AP_M1: begin
        cmd_o.mul_hi = 1'b1;
        state_d = S_AP_AD;
      end
      S_AP_AD: begin
        state_d = S_AP_W0;
      end
      S_AP_W0: begin
        cmd_o.mem_we = 1'b1;
        cmd_o.wr_src = WR_PAIR_LO;
        state_d = S_AP_W1;
      end
      S_AP_W1: begin
        cmd_o.mem_we = 1'b1;
        cmd_o.wr_src = WR_PAIR_HI;
        if (flags_i.pair_last) begin
          cmd_o.cnt_clr  = 1'b1;
          cmd_o.res_load = 1'b1;
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          cmd_o.cnt_inc = 1'b1;
          state_d = S_AP_RD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold state and registered handshake outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      busy_q  <= 1'b1;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= (state_d != S_IDLE);
      done_q  <= done_d;
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;

  // Busy tracks the idle state
  a_busy_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q == (state_q != S_IDLE))
    else $error("busy out of step with state");

  // A pair that is not the last loops back to read the next one
  a_pair_loop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_AP_W1 && !flags_i.pair_last) |=> state_q == S_AP_RD)
    else $error("apply pass left early");

  // The last pair ends the pass with a result and releases the block
  a_pass_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_AP_W1 && flags_i.pair_last) |=> (done_q && !busy_q))
    else $error("apply pass ended without result");

  // Store writes only in the sweep, at item accept or at write-back
  a_we_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.mem_we |-> (state_q == S_CLEAR || state_q == S_IDLE ||
                      state_q == S_AP_W0 || state_q == S_AP_W1))
    else $error("store write outside a write slot");

  // Counter is never cleared and advanced together
  a_cnt_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.cnt_clr && cmd_o.cnt_inc))
    else $error("counter clear and advance together");

endmodule

`default_nettype wire

// ===== verif/tb_single_qubit_gate_apply.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_single_qubit_gate_apply: self-checking bench for the single-qubit gate
// Drives write, read and apply items with random gaps, keeps its own copy of
// the amplitude store and gate registers, and checks every result strobe in
// order against the predicted amplitude and status.
// ----------------------------------------------------------------------------

import sqg_pkg::*;

// One result as the block presents it
typedef struct packed {
  logic [PORT_W-1:0] re;
  logic [PORT_W-1:0] im;
  logic [1:0]        status;
} readout_t;

// Shadow of the state vector and gate registers; predicts and checks results
class state_vector_sb;
  logic [STORE_W-1:0]  amps [DEPTH];
  logic [CFG_W-1:0]    m00, m01, m10, m11;
  logic [QCNT_W-1:0]   qcnt;
  logic [3:0]          tgt_wire;
  readout_t            awaited[$];
  int mismatches = 0;
  int checked    = 0;
  int writes     = 0;
  int reads      = 0;
  int passes     = 0;
  int pair_ops   = 0;
  int bad_index  = 0;
  int bad_wire   = 0;
  int unused     = 0;

  function new();
    foreach (amps[i]) amps[i] = '0;
    m00      = GATE_ONE;
    m01      = GATE_ZERO;
    m10      = GATE_ZERO;
    m11      = GATE_ONE;
    qcnt     = QCNT_RESET;
    tgt_wire = '0;
  endfunction

  function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    case (idx)
      CFG_M00:  m00 = val;
      CFG_M01:  m01 = val;
      CFG_M10:  m10 = val;
      CFG_M11:  m11 = val;
      CFG_QCNT: qcnt = val[QCNT_W-1:0];
      CFG_WIRE: tgt_wire = val[3:0];
      default: ;
    endcase
  endfunction

  // Clamp the qubit count to the store size
  function int qubits();
    return (qcnt > MAX_QUBITS) ? MAX_QUBITS : int'(qcnt);
  endfunction

  function logic signed [67:0] widen(logic [PORT_W-1:0] v);
    return {{(68 - PORT_W){v[PORT_W-1]}}, v};
  endfunction

  // Round half toward plus infinity, then clip to the 32-bit signed range
  function logic [PORT_W-1:0] round_sat(logic signed [67:0] acc);
    logic signed [67:0] q;
    q = (acc + (68'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    if (q > 68'sd2147483647) return 32'h7FFF_FFFF;
    if (q < -68'sd2147483648) return 32'h8000_0000;
    return q[PORT_W-1:0];
  endfunction

  // ma*va + mb*vb, each part from its exact four-product sum
  function logic [STORE_W-1:0] cmac(logic [CFG_W-1:0] ma, logic [STORE_W-1:0] va,
                                    logic [CFG_W-1:0] mb, logic [STORE_W-1:0] vb);
    logic signed [67:0] ar, ai, br, bi, xr, xi, yr, yi, acc_re, acc_im;
    ar = widen(ma[63:32]);
    ai = widen(ma[31:0]);
    br = widen(mb[63:32]);
    bi = widen(mb[31:0]);
    xr = widen(va[63:32]);
    xi = widen(va[31:0]);
    yr = widen(vb[63:32]);
    yi = widen(vb[31:0]);
    acc_re = ar * xr - ai * xi + br * yr - bi * yi;
    acc_im = ar * xi + ai * xr + br * yi + bi * yr;
    return {round_sat(acc_re), round_sat(acc_im)};
  endfunction

  // Update the shadow store for one accepted item and queue its result
  function void take_item(logic [1:0] mode, logic [ADDR_W-1:0] idx,
                          logic [PORT_W-1:0] re, logic [PORT_W-1:0] im);
    readout_t r;
    int n, b, lo_mask, hi_mask, i0, i1;
    logic [STORE_W-1:0] v0, v1;
    r = '0;
    n = qubits();
    case (mode)
      MODE_WRITE, MODE_READ: begin
        if (int'(idx) >= (1 << n)) begin
          r.status = ST_BAD_INDEX;
          bad_index++;
        end else if (mode == MODE_WRITE) begin
          amps[idx] = {re, im};
          writes++;
        end else begin
          {r.re, r.im} = amps[idx];
          reads++;
        end
      end
      MODE_APPLY: begin
        if (int'(tgt_wire) >= n) begin
          r.status = ST_BAD_WIRE;
          bad_wire++;
        end else begin
          b       = n - 1 - int'(tgt_wire);
          lo_mask = (1 << b) - 1;
          hi_mask = ~((1 << (b + 1)) - 1);
          for (int k = 0; k < (1 << (n - 1)); k++) begin
            i0 = ((k << 1) & hi_mask) | (k & lo_mask);
            i1 = i0 | (1 << b);
            v0 = amps[i0];
            v1 = amps[i1];
            amps[i0] = cmac(m00, v0, m01, v1);
            amps[i1] = cmac(m10, v0, m11, v1);
            pair_ops++;
          end
          passes++;
        end
      end
      default: unused++;
    endcase
    awaited.push_back(r);
  endfunction

  task report(string msg);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // Compare one result strobe with the oldest prediction
  task check_readout(logic [PORT_W-1:0] re, logic [PORT_W-1:0] im, logic [1:0] st);
    readout_t e;
    if (awaited.size() == 0) begin
      report($sformatf("result with none pending: re=%h im=%h status=%0d", re, im, st));
      return;
    end
    e = awaited.pop_front();
    checked++;
    if (re !== e.re) report($sformatf("out_re %h, predicted %h", re, e.re));
    if (im !== e.im) report($sformatf("out_im %h, predicted %h", im, e.im));
    if (st !== e.status) report($sformatf("status %0d, predicted %0d", st, e.status));
  endtask
endclass

module tb_single_qubit_gate_apply;

  localparam logic [1:0]        MODE_UNUSED = 2'd3;
  localparam int                ITEM_TARGET = 1100;
  localparam logic [PORT_W-1:0] Q_ONE       = 32'h4000_0000;
  localparam logic [PORT_W-1:0] Q_HALF      = 32'h2000_0000;
  localparam logic [PORT_W-1:0] Q_RT2       = 32'h2D41_3CCD;
  localparam logic [PORT_W-1:0] Q_MAX       = 32'h7FFF_FFFF;
  localparam logic [PORT_W-1:0] Q_MIN       = 32'h8000_0000;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 start_i     = 1'b0;
  logic [1:0]           mode_i      = MODE_WRITE;
  logic [ADDR_W-1:0]    amp_index_i = '0;
  logic [PORT_W-1:0]    in_re_i     = '0;
  logic [PORT_W-1:0]    in_im_i     = '0;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i   = '0;
  logic [CFG_W-1:0]     cfg_wdata_i = '0;
  logic                 busy_o;
  logic                 done_o;
  logic [PORT_W-1:0]    out_re_o;
  logic [PORT_W-1:0]    out_im_o;
  logic [1:0]           status_o;

  state_vector_sb sb;
  int items_sent = 0;
  int big_phases = 0;

  single_qubit_gate_apply u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .mode_i      (mode_i),
    .amp_index_i (amp_index_i),
    .in_re_i     (in_re_i),
    .in_im_i     (in_im_i),
    .done_o      (done_o),
    .out_re_o    (out_re_o),
    .out_im_o    (out_im_o),
    .status_o    (status_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Check every result strobe
  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_readout(out_re_o, out_im_o, status_o);
  end

  // Hard stop well beyond the slowest run
  initial begin
    #20_000_000;
    $display("[single_qubit_gate_apply] ERROR");
    $finish;
  end

  // Random Q2.30 part: full range or within +-1.0
  function automatic logic [PORT_W-1:0] bounded_part();
    longint v;
    v = $urandom_range(0, 32'h8000_0000);
    v = v - 64'sh4000_0000;
    return v[PORT_W-1:0];
  endfunction

  function automatic logic [PORT_W-1:0] rand_part();
    if ($urandom_range(0, 1) == 0) return $urandom;
    return bounded_part();
  endfunction

  function automatic logic [PORT_W-1:0] gate_const();
    case ($urandom_range(0, 6))
      0:       return '0;
      1:       return Q_HALF;
      2:       return -Q_HALF;
      3:       return Q_RT2;
      4:       return -Q_RT2;
      5:       return Q_ONE;
      default: return -Q_ONE;
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] rand_gate_elem();
    case ($urandom_range(0, 2))
      0:       return {$urandom, $urandom};
      1:       return {gate_const(), gate_const()};
      default: return {bounded_part(), bounded_part()};
    endcase
  endfunction

  // Present one item and hold it until accepted; idle first at random
  task automatic send_item(input logic [1:0] md, input logic [ADDR_W-1:0] idx,
                           input logic [PORT_W-1:0] re, input logic [PORT_W-1:0] im);
    bit idle_on;
    idle_on = !(items_sent >= 400 && items_sent < 700);
    if (idle_on && $urandom_range(0, 99) < 24) begin
      @(negedge clk_i);
      start_i <= 1'b0;
      repeat ($urandom_range(0, 1)) @(negedge clk_i);
    end
    @(negedge clk_i);
    start_i     <= 1'b1;
    mode_i      <= md;
    amp_index_i <= idx;
    in_re_i     <= re;
    in_im_i     <= im;
    do @(posedge clk_i); while (busy_o);
    sb.take_item(md, idx, re, im);
    items_sent++;
  endtask

  // Drop start and wait until the block is idle with nothing outstanding
  task automatic settle();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (sb.awaited.size() != 0 || busy_o) @(posedge clk_i);
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    sb.write_reg(idx, val);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic load_gate(input logic [CFG_W-1:0] g00, input logic [CFG_W-1:0] g01,
                           input logic [CFG_W-1:0] g10, input logic [CFG_W-1:0] g11,
                           input logic [QCNT_W-1:0] qn, input logic [3:0] tw);
    set_reg(CFG_M00, g00);
    set_reg(CFG_M01, g01);
    set_reg(CFG_M10, g10);
    set_reg(CFG_M11, g11);
    set_reg(CFG_QCNT, CFG_W'(qn));
    set_reg(CFG_WIRE, CFG_W'(tw));
  endtask

  // Sprinkle an arbitrary item, any mode and any index
  task automatic maybe_noise();
    if ($urandom_range(0, 99) < 8)
      send_item(2'($urandom_range(MODE_WRITE, MODE_UNUSED)), ADDR_W'($urandom),
                rand_part(), rand_part());
  endtask

  task automatic directed_items();
    // Extremes at the store edges, identity gate on all ten qubits
    send_item(MODE_WRITE, 0, Q_MAX, Q_MIN);
    send_item(MODE_WRITE, DEPTH - 1, Q_MIN, Q_MAX);
    send_item(MODE_WRITE, DEPTH / 2, Q_ONE, -Q_ONE);
    send_item(MODE_READ, 0, '0, '0);
    send_item(MODE_READ, DEPTH - 1, '0, '0);
    send_item(MODE_READ, 777, '0, '0);
    send_item(MODE_UNUSED, DEPTH - 1, Q_MAX, Q_MIN);
    send_item(MODE_APPLY, 0, '0, '0);
    send_item(MODE_READ, DEPTH / 2, '0, '0);

    // Half-scale gate on one qubit: rounding ties go up
    settle();
    load_gate({Q_HALF, 32'h0}, GATE_ZERO, GATE_ZERO, {32'h0, Q_HALF}, 1, 0);
    send_item(MODE_WRITE, 0, 32'd1, -32'd1);
    send_item(MODE_WRITE, 1, 32'd3, -32'd3);
    send_item(MODE_APPLY, 0, '0, '0);
    send_item(MODE_READ, 0, '0, '0);
    send_item(MODE_READ, 1, '0, '0);
    send_item(MODE_WRITE, 2, Q_ONE, Q_ONE);

    // Unnormalized Hadamard on full-scale inputs: drive saturation
    settle();
    load_gate({Q_ONE, 32'h0}, {Q_ONE, 32'h0}, {Q_ONE, 32'h0}, {-Q_ONE, 32'h0}, 2, 1);
    send_item(MODE_WRITE, 0, Q_MAX, Q_MIN);
    send_item(MODE_WRITE, 1, Q_MAX, Q_MIN);
    send_item(MODE_APPLY, 0, '0, '0);
    send_item(MODE_READ, 0, '0, '0);
    send_item(MODE_READ, 1, '0, '0);

    // Target wire past the last qubit
    settle();
    set_reg(CFG_WIRE, CFG_W'(2));
    send_item(MODE_APPLY, 0, '0, '0);

    // Zero qubits: one amplitude, every apply rejected; spare indexes ignored
    settle();
    set_reg(CFG_QCNT, CFG_W'(0));
    set_reg(CFG_IDX_W'(CFG_WIRE + 1), {$urandom, $urandom});
    set_reg(CFG_IDX_W'((1 << CFG_IDX_W) - 1), {$urandom, $urandom});
    send_item(MODE_APPLY, 0, '0, '0);
    send_item(MODE_READ, 0, '0, '0);
    send_item(MODE_READ, 1, '0, '0);
    send_item(MODE_WRITE, 0, Q_MIN, Q_MAX);
  endtask

  // One setting of the gate: fill the state, apply a few times, read back
  task automatic run_phase();
    logic [QCNT_W-1:0] qn;
    logic [3:0] tw;
    int n, amp_cnt, r, fill;
    bit sweep;
    settle();
    r = $urandom_range(0, 99);
    if (r < 6) begin
      qn = 0;
    end else if (r < 12 && big_phases < 8) begin
      qn = QCNT_W'($urandom_range(MAX_QUBITS + 1, (1 << QCNT_W) - 1));
      big_phases++;
    end else if (r < 22 && big_phases < 8) begin
      qn = QCNT_W'($urandom_range(6, MAX_QUBITS));
      big_phases++;
    end else begin
      qn = QCNT_W'($urandom_range(1, 5));
    end
    n = (qn > MAX_QUBITS) ? MAX_QUBITS : int'(qn);
    if (n > 0 && $urandom_range(0, 99) < 85) tw = 4'($urandom_range(0, n - 1));
    else tw = 4'($urandom_range(0, 15));
    load_gate(rand_gate_elem(), rand_gate_elem(), rand_gate_elem(), rand_gate_elem(), qn, tw);
    if ($urandom_range(0, 7) == 0)
      set_reg(CFG_IDX_W'($urandom_range(CFG_WIRE + 1, (1 << CFG_IDX_W) - 1)),
              {$urandom, $urandom});

    amp_cnt = 1 << n;
    sweep   = (amp_cnt <= 32);
    fill    = sweep ? amp_cnt : 16;

    for (int i = 0; i < fill; i++) begin
      send_item(MODE_WRITE, ADDR_W'(sweep ? i : $urandom_range(0, amp_cnt - 1)),
                rand_part(), rand_part());
      maybe_noise();
    end
    repeat ($urandom_range(1, 3)) begin
      send_item(MODE_APPLY, ADDR_W'($urandom), rand_part(), rand_part());
      repeat ($urandom_range(0, 3)) begin
        send_item(MODE_READ, ADDR_W'($urandom_range(0, amp_cnt - 1)), '0, '0);
        maybe_noise();
      end
    end
    for (int i = 0; i < fill; i++) begin
      send_item(MODE_READ, ADDR_W'(sweep ? i : $urandom_range(0, amp_cnt - 1)),
                rand_part(), rand_part());
      maybe_noise();
    end
  endtask

  initial begin
    sb = new();
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    directed_items();
    while (items_sent < ITEM_TARGET) run_phase();

    // Drain, then leave room for any stray strobe
    settle();
    repeat (16) @(posedge clk_i);

    $display("covered %0d items: %0d writes, %0d reads, %0d gate passes over %0d pairs",
             items_sent, sb.writes, sb.reads, sb.passes, sb.pair_ops);
    $display("rejected %0d bad index, %0d bad wire, %0d unused mode; %0d checked, %0d bad",
             sb.bad_index, sb.bad_wire, sb.unused, sb.checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.awaited.size() == 0) begin
      $display("[single_qubit_gate_apply] OK");
    end else begin
      $display("[single_qubit_gate_apply] ERROR");
    end
    $finish;
  end

endmodule
